/* rtl/ordered_array_store_unit_assert.svh */
// ============================================================================
// ordered array store assertion macros
// concurrent checks used by the ordered array store rtl, empty for synthesis
// ============================================================================
`ifndef ORDERED_ARRAY_STORE_UNIT_ASSERT_SVH
`define ORDERED_ARRAY_STORE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define OAS_ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ordered array store: property violated");

// condition must never be seen outside reset
`define OAS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ordered array store: forbidden condition seen");

`else

`define OAS_ASSERT_HOLDS(label, clk, rst_n, prop)
`define OAS_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

/* rtl/oas_pkg.sv */
// ============================================================================
// oas_pkg
// shared types, field widths and codes of the ordered array store
// ============================================================================
`default_nettype none

package oas_pkg;

    // fixed field widths of the request and response beats
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int VAL_W     = 32;
    localparam int ST_W      = 2;
    localparam int FIDX_W    = 4;
    localparam int CNT_OUT_W = 5;

    // default storage shape
    localparam int CAPACITY_DEF   = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4,
        OP_FIND   = 3'd5
    } t_op;

    // response status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    // command broadcast to every cell, flags only set for a legal request
    typedef struct packed {
        logic wr;
        logic app;
        logic ins;
        logic rem;
        logic find;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* rtl/oas_if.sv */
// ============================================================================
// oas request and response channels
// valid/ready channels carrying the request and response beats
// ============================================================================
`default_nettype none

interface oas_req_if import oas_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;

    modport source (output valid, operation, position, value, input ready);
    modport sink   (input valid, operation, position, value, output ready);
endinterface

interface oas_rsp_if import oas_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ST_W-1:0]      status;
    logic [VAL_W-1:0]     data;
    logic [FIDX_W-1:0]    found_index;
    logic [CNT_OUT_W-1:0] count;

    modport source (output valid, status, data, found_index, count, input ready);
    modport sink   (input valid, status, data, found_index, count, output ready);
endinterface

`default_nettype wire

/* rtl/oas_cell.sv */
// ============================================================================
// oas_cell
// one slot of the store: loads, shifts from a neighbor, compares for find
// ============================================================================
`default_nettype none

module oas_cell import oas_pkg::*; #(
    parameter int INDEX = 0,
    parameter int CMP_W = POS_W,
    parameter int SW    = ELEM_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire t_cell_cmd        i_cmd,
    input  wire logic [CMP_W-1:0] i_pos,
    input  wire logic [CMP_W-1:0] i_cnt,
    input  wire logic [SW-1:0]    i_value,
    input  wire logic [SW-1:0]    i_left,
    input  wire logic [SW-1:0]    i_right,
    output logic      [SW-1:0]    o_elem,
    output logic                  o_match
);

    localparam logic [CMP_W-1:0] IDX      = CMP_W'(INDEX);
    localparam logic [CMP_W-1:0] IDX_NEXT = CMP_W'(INDEX + 1);

    logic [SW-1:0] r_elem;
    logic [SW-1:0] n_elem;
    logic          r_match;

    // slot update: direct load, shift up from the left, shift down from the right
    always_comb begin
        n_elem = r_elem;
        priority if (i_cmd.wr && (IDX == i_pos)) begin
            n_elem = i_value;
        end else if (i_cmd.app && (IDX == i_cnt)) begin
            n_elem = i_value;
        end else if (i_cmd.ins && (IDX == i_pos)) begin
            n_elem = i_value;
        end else if (i_cmd.ins && (IDX > i_pos) && (IDX <= i_cnt)) begin
            n_elem = i_left;
        end else if (i_cmd.rem && (IDX >= i_pos) && (IDX_NEXT < i_cnt)) begin
            n_elem = i_right;
        end else begin
            n_elem = r_elem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_elem <= n_elem;
    end

    // match flag updated only on a find and held until the next one, so it is kept until the result is taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_match <= (IDX < i_cnt) && (r_elem == i_value);
        end
    end

    assign o_elem  = r_elem;
    assign o_match = r_match;

endmodule

`default_nettype wire

/* rtl/oas_find_enc.sv */
// ============================================================================
// oas_find_enc
// lowest-index priority encoder over the per-cell match flags
// ============================================================================
`default_nettype none

module oas_find_enc import oas_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY_DEF)
) (
    input  wire logic [CAPACITY-1:0] i_match,
    output logic                     o_any,
    output logic      [IDX_W-1:0]    o_index
);

    // scan from the top so the lowest set flag wins
    always_comb begin
        o_index = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = IDX_W'(i);
            end
        end
    end

    assign o_any = |i_match;

endmodule

`default_nettype wire

/* rtl/ordered_array_store_unit.sv */
// Throughput: one request per cycle while responses drain; the cell row applies every
// operation on the accepted beat, then one pending stage feeds the output register.
// Reset: synchronous active low, empties the store (count zero) and drops pending
// results; element slots keep their contents and are not cleared.
// ============================================================================
// ordered_array_store_unit
// packed array with read, write, append, insert, remove and find operations
// ============================================================================
`default_nettype none

`include "ordered_array_store_unit_assert.svh"

module ordered_array_store_unit import oas_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    oas_req_if.sink   i_req,
    oas_rsp_if.source o_rsp
);

    localparam int SW    = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_load;
    logic r_busy;
    logic r_o_valid;

    assign out_load    = r_busy && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_busy || out_load;
    assign in_fire     = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [SW-1:0]    value_s;
    logic             pos_live;
    logic             ins_ok;
    logic             full;
    logic             take_data;
    t_cell_cmd        cmd;
    t_status          dec_status;

    assign pos_c    = CMP_W'(i_req.position);
    assign cnt_c    = CMP_W'(r_count);
    assign value_s  = i_req.value[SW-1:0];
    assign pos_live = pos_c < cnt_c;
    assign ins_ok   = pos_c <= cnt_c;
    assign full     = r_count == CNT_W'(CAPACITY);

    always_comb begin
        cmd        = '0;
        dec_status = ST_OK;
        take_data  = 1'b0;
        n_count    = r_count;
        unique case (i_req.operation)
            OP_READ: begin
                if (pos_live) begin
                    take_data = 1'b1;
                end else begin
                    dec_status = ST_RANGE;
                end
            end
            OP_WRITE: begin
                if (pos_live) begin
                    take_data = 1'b1;
                    cmd.wr    = in_fire;
                end else begin
                    dec_status = ST_RANGE;
                end
            end
            OP_APPEND: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    cmd.app = in_fire;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (!ins_ok) begin
                    dec_status = ST_RANGE;
                end else if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    cmd.ins = in_fire;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (pos_live) begin
                    take_data = 1'b1;
                    cmd.rem   = in_fire;
                    n_count   = r_count - CNT_W'(1);
                end else begin
                    dec_status = ST_RANGE;
                end
            end
            OP_FIND: begin
                cmd.find = in_fire;
            end
            default: begin
                dec_status = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    logic [SW-1:0]       w_elem [CAPACITY];
    logic [CAPACITY-1:0] w_match;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [SW-1:0] left_elem;
        logic [SW-1:0] right_elem;

        if (g == 0) begin : g_first
            assign left_elem = '0;
        end else begin : g_inner_l
            assign left_elem = w_elem[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_elem = '0;
        end else begin : g_inner_r
            assign right_elem = w_elem[g+1];
        end

        oas_cell #(
            .INDEX (g),
            .CMP_W (CMP_W),
            .SW    (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (pos_c),
            .i_cnt   (cnt_c),
            .i_value (value_s),
            .i_left  (left_elem),
            .i_right (right_elem),
            .o_elem  (w_elem[g]),
            .o_match (w_match[g])
        );
    end

    // old element at the requested position
    logic [SW-1:0] rd_elem;

    always_comb begin
        rd_elem = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_c == CMP_W'(i)) begin
                rd_elem = w_elem[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // count and pending result stage
    // ------------------------------------------------------------------
    t_status          r_pend_status;
    logic [SW-1:0]    r_pend_data;
    logic [CNT_W-1:0] r_pend_count;
    logic             r_pend_find;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count <= n_count;
                r_busy  <= 1'b1;
            end else if (out_load) begin
                r_busy  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_pend_status <= dec_status;
            r_pend_data   <= take_data ? rd_elem : '0;
            r_pend_count  <= n_count;
            r_pend_find   <= cmd.find;
        end
    end

    // ------------------------------------------------------------------
    // find encode and output register
    // ------------------------------------------------------------------
    logic             enc_any;
    logic [IDX_W-1:0] enc_index;

    oas_find_enc #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_find_enc (
        .i_match (w_match),
        .o_any   (enc_any),
        .o_index (enc_index)
    );

    logic [ST_W-1:0]      r_o_status;
    logic [VAL_W-1:0]     r_o_data;
    logic [FIDX_W-1:0]    r_o_found;
    logic [CNT_OUT_W-1:0] r_o_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_data  <= VAL_W'(r_pend_data);
            r_o_count <= CNT_OUT_W'(r_pend_count);
            if (r_pend_find) begin
                r_o_status <= enc_any ? ST_OK : ST_ABSENT;
                r_o_found  <= enc_any ? FIDX_W'(enc_index) : '0;
            end else begin
                r_o_status <= r_pend_status;
                r_o_found  <= '0;
            end
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.data        = r_o_data;
    assign o_rsp.found_index = r_o_found;
    assign o_rsp.count       = r_o_count;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `OAS_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(CAPACITY))
    `OAS_ASSERT_HOLDS(a_count_only_on_beat, i_clk, i_rst_n, !in_fire |=> $stable(r_count))
    `OAS_ASSERT_HOLDS(a_pending_kept, i_clk, i_rst_n, (r_busy && !out_load) |=> r_busy)
    `OAS_ASSERT_HOLDS(a_error_no_data, i_clk, i_rst_n, (r_o_valid && (r_o_status != ST_OK)) |-> (r_o_data == '0))

endmodule

`default_nettype wire

/* bench/tb_ordered_array_store_unit.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_ordered_array_store_unit
// self-checking bench for the ordered array store: a directed run covers the
// empty and full store, out-of-range positions, inserts at the head, middle
// and end, finds that hit and miss, and the spare operation codes; a random
// run of grow, shrink and mixed segments follows. Every accepted request is
// applied to a shadow copy of the store, and each response beat is compared
// field by field with the oldest expected response. Request bursts with gaps
// and a patterned response stall exercise the handshake on both sides.
// ============================================================================
module tb_ordered_array_store_unit;
    import oas_pkg::*;

    localparam int STORE_DEPTH = CAPACITY_DEF;

    // spare operation codes that the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [VAL_W-1:0]     data;
        logic [FIDX_W-1:0]    fidx;
        logic [CNT_OUT_W-1:0] cnt;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    oas_req_if req_if ();
    oas_rsp_if rsp_if ();

    ordered_array_store_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // shadow copy of the store
    logic [VAL_W-1:0] shadow_mem [STORE_DEPTH];
    int               shadow_cnt = 0;

    t_req pending_req [$];
    t_rsp awaited_rsp [$];
    t_req cur_req;

    int gen_cnt     = 0;
    int beats_sent  = 0;
    int rsp_popped  = 0;
    int mismatches  = 0;
    int total_reqs  = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int rx_cyc      = 0;

    // apply one request to the shadow store and return its response
    function automatic t_rsp compute_response(t_req r);
        t_rsp res;
        int   k;
        res = '{status: ST_OK, data: '0, fidx: '0, cnt: '0};
        case (r.op)
            OP_READ: begin
                if (r.pos < shadow_cnt) res.data = shadow_mem[r.pos];
                else res.status = ST_RANGE;
            end
            OP_WRITE: begin
                if (r.pos < shadow_cnt) begin
                    res.data = shadow_mem[r.pos];
                    shadow_mem[r.pos] = r.val;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_APPEND: begin
                if (shadow_cnt >= STORE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_mem[shadow_cnt] = r.val;
                    shadow_cnt++;
                end
            end
            OP_INSERT: begin
                // range check wins over the full check
                if (r.pos > shadow_cnt) begin
                    res.status = ST_RANGE;
                end else if (shadow_cnt >= STORE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = shadow_cnt; k > r.pos; k--)
                        shadow_mem[k] = shadow_mem[k-1];
                    shadow_mem[r.pos] = r.val;
                    shadow_cnt++;
                end
            end
            OP_REMOVE: begin
                if (r.pos < shadow_cnt) begin
                    res.data = shadow_mem[r.pos];
                    for (k = r.pos; k + 1 < shadow_cnt; k++)
                        shadow_mem[k] = shadow_mem[k+1];
                    shadow_cnt--;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            OP_FIND: begin
                // lowest live index wins
                res.status = ST_ABSENT;
                for (k = 0; k < shadow_cnt; k++) begin
                    if (res.status == ST_ABSENT && shadow_mem[k] == r.val) begin
                        res.status = ST_OK;
                        res.fidx   = k[FIDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        res.cnt = shadow_cnt[CNT_OUT_W-1:0];
        return res;
    endfunction

    // queue a request and track the live count it leaves behind
    task automatic push_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        pending_req.push_back('{op: op, pos: pos, val: val});
        case (op)
            OP_APPEND: if (gen_cnt < STORE_DEPTH) gen_cnt++;
            OP_INSERT: if (pos <= gen_cnt && gen_cnt < STORE_DEPTH) gen_cnt++;
            OP_REMOVE: if (pos < gen_cnt) gen_cnt--;
            default: ;
        endcase
    endtask

    // values drawn from a small set so that finds often hit and duplicates occur
    function automatic logic [VAL_W-1:0] pick_value();
        int w;
        w = $urandom_range(0, 19);
        if (w == 0) return '0;
        if (w == 1) return '1;
        if (w < 11) return 32'hC0DE_0000 + $urandom_range(0, 7);
        return $urandom;
    endfunction

    task automatic build_directed();
        int i;
        push_req(OP_READ, 5'd0, 32'h0);            // read on empty store
        push_req(OP_REMOVE, 5'd0, 32'h0);          // remove on empty store
        push_req(OP_FIND, 5'd0, 32'h0);            // find on empty store
        push_req(OP_INSERT, 5'd1, 32'h1111_1111);  // insert past the end
        push_req(OP_INSERT, 5'd0, 32'hFFFF_FFFF);  // insert at end of empty store
        push_req(OP_APPEND, 5'd31, 32'h0000_0000);
        push_req(OP_INSERT, 5'd1, 32'h1234_5678);  // insert in the middle
        push_req(OP_INSERT, 5'd3, 32'hA5A5_A5A5);  // insert at the end
        push_req(OP_INSERT, 5'd0, 32'h8000_0001);  // insert at the head
        push_req(OP_WRITE, 5'd0, 32'h5A5A_5A5A);
        push_req(OP_FIND, 5'd0, 32'h0000_0000);    // hit
        push_req(OP_FIND, 5'd0, 32'hDEAD_BEEF);    // miss
        push_req(OP_REMOVE, 5'd2, 32'h0);          // remove from the middle
        push_req(OP_SPARE6, 5'd31, 32'hFFFF_FFFF);
        push_req(OP_SPARE7, 5'd16, 32'h0);
        // fill up to capacity
        for (i = gen_cnt; i < STORE_DEPTH; i++)
            push_req(OP_APPEND, 5'd0, 32'h0101_0101 * i);
        push_req(OP_APPEND, 5'd0, 32'h7777_7777);  // full
        push_req(OP_INSERT, 5'd16, 32'h7777_7777); // full, position valid
        push_req(OP_INSERT, 5'd31, 32'h7777_7777); // range before full
        push_req(OP_READ, 5'd15, 32'h0);
        push_req(OP_REMOVE, 5'd15, 32'h0);         // remove the last entry
        push_req(OP_WRITE, 5'd15, 32'h0);          // position equal to count
    endtask

    task automatic build_random(input int n_items);
        int               done;
        int               seg_len;
        int               mode;
        int               w;
        int               app_w;
        int               ins_w;
        int               rem_w;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        done = 0;
        while (done < n_items) begin
            seg_len = $urandom_range(10, 40);
            mode    = $urandom_range(0, 2);
            // grow, shrink or mixed weights for append, insert, remove
            app_w = (mode == 0) ? 30 : (mode == 1) ? 8  : 16;
            ins_w = (mode == 0) ? 30 : (mode == 1) ? 8  : 16;
            rem_w = (mode == 0) ? 8  : (mode == 1) ? 40 : 18;
            repeat (seg_len) begin
                w = $urandom_range(0, 99);
                if (w < 2) begin
                    op = (w == 0) ? OP_SPARE6 : OP_SPARE7;
                end else begin
                    w = $urandom_range(0, 99);
                    if (w < app_w) op = OP_APPEND;
                    else if (w < app_w + ins_w) op = OP_INSERT;
                    else if (w < app_w + ins_w + rem_w) op = OP_REMOVE;
                    else begin
                        w = $urandom_range(0, 2);
                        op = (w == 0) ? OP_READ : (w == 1) ? OP_WRITE : OP_FIND;
                    end
                end
                // mostly live positions, some anywhere in the field
                if ($urandom_range(0, 9) < 8) begin
                    if (op == OP_INSERT) pos = POS_W'($urandom_range(0, gen_cnt));
                    else pos = (gen_cnt > 0) ? POS_W'($urandom_range(0, gen_cnt - 1)) : '0;
                end else begin
                    pos = POS_W'($urandom_range(0, 31));
                end
                push_req(op, pos, pick_value());
                done++;
            end
        end
    endtask

    // request driver, bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                awaited_rsp.push_back(compute_response(cur_req));
                beats_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0 || pending_req.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    req_if.valid <= 1'b0;
                end else begin
                    cur_req = pending_req.pop_front();
                    req_if.valid     <= 1'b1;
                    req_if.operation <= cur_req.op;
                    req_if.position  <= cur_req.pos;
                    req_if.value     <= cur_req.val;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // response monitor and stall pattern
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        int   mode;
        rx_cyc++;
        mode = (rx_cyc / 97) % 4;
        case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_if.ready <= ((rx_cyc % 5) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_rsp.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected response beat: status %0d data %h idx %0d count %0d",
                             rsp_if.status, rsp_if.data, rsp_if.found_index, rsp_if.count);
                mismatches++;
            end else begin
                exp_rsp = awaited_rsp.pop_front();
                if (rsp_if.status !== exp_rsp.status || rsp_if.data !== exp_rsp.data ||
                    rsp_if.found_index !== exp_rsp.fidx || rsp_if.count !== exp_rsp.cnt) begin
                    if (mismatches < 10)
                        $display({"mismatch on response %0d: exp status %0d data %h idx %0d ",
                                  "count %0d, got status %0d data %h idx %0d count %0d"},
                                 rsp_popped, exp_rsp.status, exp_rsp.data, exp_rsp.fidx,
                                 exp_rsp.cnt, rsp_if.status, rsp_if.data,
                                 rsp_if.found_index, rsp_if.count);
                    mismatches++;
                end
                rsp_popped++;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = '0;
        req_if.position  = '0;
        req_if.value     = '0;
        rsp_if.ready     = 1'b0;
        build_directed();
        build_random(500);
        total_reqs = pending_req.size();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (beats_sent == total_reqs && rsp_popped == total_reqs);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/oas_pkg.sv
rtl/oas_if.sv
rtl/oas_cell.sv
rtl/oas_find_enc.sv
rtl/ordered_array_store_unit.sv
bench/tb_ordered_array_store_unit.sv
